@@ rtl/core/rsfc_pkg.sv @@
// rsfc_pkg: shared types for the ray/sphere far clip unit
// no dependencies; used by rsfc_isqrt and ray_sphere_far_clip_unit
`default_nettype none

package rsfc_pkg;

	// control that travels alongside each transaction in the pipeline
	typedef struct packed {
		logic valid;
		logic hit;
	} ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/rsfc_isqrt.sv @@
// rsfc_isqrt: pipelined integer square root, one root bit per stage
// depends on rsfc_pkg (ctl_t); carries an opaque tag vector alongside
`default_nettype none

module rsfc_isqrt #(
	parameter int ROOT_W = 28,
	parameter int TAG_W = 8
) (
	input wire clk,
	input wire arst_n,
	input var rsfc_pkg::ctl_t in_ctl,
	input wire [2*ROOT_W-1:0] in_rad,
	input wire [TAG_W-1:0] in_tag,
	output rsfc_pkg::ctl_t out_ctl,
	output logic [ROOT_W-1:0] out_root,
	output logic [TAG_W-1:0] out_tag
);

	localparam int RAD_W = 2 * ROOT_W;

	genvar j;
	for (j = 0; j < ROOT_W; j++) begin : g_step
		localparam int B = ROOT_W - 1 - j;
		rsfc_pkg::ctl_t ctl_in;
		logic [RAD_W-1:0] rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [TAG_W-1:0] tag_in;
		logic [RAD_W-1:0] trial;
		logic take;
		// stage registers
		rsfc_pkg::ctl_t ctl_s;
		logic [RAD_W-1:0] rem_s;
		logic [ROOT_W-1:0] root_s;
		logic [TAG_W-1:0] tag_s;

		if (j == 0) begin : g_first
			assign ctl_in = in_ctl;
			assign rem_in = in_rad;
			assign root_in = '0;
			assign tag_in = in_tag;
		end else begin : g_next
			assign ctl_in = g_step[j-1].ctl_s;
			assign rem_in = g_step[j-1].rem_s;
			assign root_in = g_step[j-1].root_s;
			assign tag_in = g_step[j-1].tag_s;
		end

		// (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
		assign trial = ({{ROOT_W{1'b0}}, root_in} << (B + 1))
			| ({{(RAD_W-1){1'b0}}, 1'b1} << (2 * B));
		assign take = rem_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s <= '0;
			end else begin
				ctl_s <= ctl_in;
			end
		end

		always_ff @(posedge clk) begin
			tag_s <= tag_in;
			if (take) begin
				rem_s <= rem_in - trial;
				root_s <= root_in | (ROOT_W'(1) << B);
			end else begin
				rem_s <= rem_in;
				root_s <= root_in;
			end
		end
	end

	assign out_ctl = g_step[ROOT_W-1].ctl_s;
	assign out_root = g_step[ROOT_W-1].root_s;
	assign out_tag = g_step[ROOT_W-1].tag_s;

endmodule

`default_nettype wire

@@ rtl/core/ray_sphere_far_clip_unit.sv @@
// ray_sphere_far_clip_unit: far intersection of a ray with a sphere, fully pipelined
// depends on rsfc_pkg (ctl_t) and rsfc_isqrt (square root pipeline)
`default_nettype none

// One transaction per clock: a transaction is taken on every rising edge with
// start high (busy is always low, the unit never stalls). Each transaction
// gives exactly one result, shown for one cycle with done high, in order.
// The square root resolves one root bit per stage over COORD_WIDTH + 4
// stages; six stages before it form the projection and the distance test,
// three after it scale the direction and saturate.
// The receiver cannot hold results off, so it must take done every cycle.
// Write the radius (cfg_we, cfg_wdata) only while no transaction is in flight;
// it is squared in the cycle after the write.
// On a miss hit is low and clip_x/y/z read zero.

module ray_sphere_far_clip_unit #(
	parameter int COORD_WIDTH = 24,
	parameter int DIR_FRAC_BITS = 14
) (
	input wire clk,
	input wire arst_n,
	// transaction in
	input wire start,
	output logic busy,
	input wire signed [COORD_WIDTH-1:0] origin_x,
	input wire signed [COORD_WIDTH-1:0] origin_y,
	input wire signed [COORD_WIDTH-1:0] origin_z,
	input wire signed [DIR_FRAC_BITS+1:0] dir_x,
	input wire signed [DIR_FRAC_BITS+1:0] dir_y,
	input wire signed [DIR_FRAC_BITS+1:0] dir_z,
	input wire signed [COORD_WIDTH-1:0] center_x,
	input wire signed [COORD_WIDTH-1:0] center_y,
	input wire signed [COORD_WIDTH-1:0] center_z,
	// radius register
	input wire cfg_we,
	input wire [COORD_WIDTH-2:0] cfg_wdata,
	// result out
	output logic done,
	output logic hit,
	output logic signed [COORD_WIDTH-1:0] clip_x,
	output logic signed [COORD_WIDTH-1:0] clip_y,
	output logic signed [COORD_WIDTH-1:0] clip_z
);

	localparam int W = COORD_WIDTH;
	localparam int F = DIR_FRAC_BITS;
	localparam int DW = F + 2;          // direction
	localparam int RADW = W - 1;        // radius
	localparam int VW = W + 1;          // center minus origin
	localparam int PDW = VW + DW;       // one term of the dot product
	localparam int DOTW = PDW + 2;      // dot product
	localparam int SQPW = 2 * VW;       // one squared component
	localparam int LW = 2 * W + 2;      // squared length of v
	localparam int TW = W + 3;          // projection t, Q.8
	localparam int PW = 2 * TW + 2;     // radicand and its sign
	localparam int SQW = PW / 2;        // square root result
	localparam int DSW = W + 5;         // far distance t + s
	localparam int PRW = DSW + 1 + DW;  // distance times direction
	localparam int SHW = PRW - F;       // after the rounding shift
	localparam int SUMW = SHW + 1;      // plus origin

	localparam logic [DOTW-1:0] DOT_HALF = DOTW'(1) << (F - 1);
	localparam logic [PRW-1:0] PROD_HALF = PRW'(1) << (F - 1);
	localparam logic [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

	// payload handed through the square root stages
	typedef struct packed {
		logic [TW-1:0] t;
		logic [2:0][DW-1:0] dir;
		logic [2:0][W-1:0] org;
	} carry_t;

	// inputs as per-axis arrays
	logic signed [W-1:0] org_in [3];
	logic signed [DW-1:0] dir_in [3];
	logic signed [W-1:0] cen_in [3];

	assign org_in[0] = origin_x;
	assign org_in[1] = origin_y;
	assign org_in[2] = origin_z;
	assign dir_in[0] = dir_x;
	assign dir_in[1] = dir_y;
	assign dir_in[2] = dir_z;
	assign cen_in[0] = center_x;
	assign cen_in[1] = center_y;
	assign cen_in[2] = center_z;

	// never stalls
	assign busy = 1'b0;

	// radius register and its square
	logic [RADW-1:0] radius_q;
	logic [2*RADW-1:0] r2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
			r2_q <= '0;
		end else begin
			if (cfg_we) begin
				radius_q <= cfg_wdata;
			end
			r2_q <= radius_q * radius_q;
		end
	end

	// pipeline valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	rsfc_pkg::ctl_t ctl_s6, ctl_sq, ctl_s7, ctl_s8;
	logic done_q;

	// stage payload
	logic signed [VW-1:0] vec_s1 [3];
	logic signed [DW-1:0] dir_s1 [3], dir_s2 [3], dir_s3 [3], dir_s4 [3], dir_s5 [3];
	logic signed [W-1:0] org_s1 [3], org_s2 [3], org_s3 [3], org_s4 [3], org_s5 [3];
	logic signed [PDW-1:0] pd_s2 [3];
	logic signed [SQPW-1:0] sq_s2 [3];
	logic signed [DOTW-1:0] dot_s3;
	logic [LW-1:0] len2_s3, len2_s4, len2_s5;
	logic neg_s4, neg_s5;
	logic [TW-1:0] t_s4, t_s5;
	logic [2*TW-1:0] t2_s5;
	logic [PW-1:0] diff_s6;
	carry_t carry_s6, carry_sq;
	logic [SQW-1:0] root_sq;
	logic [DSW-1:0] dist_s7;
	logic signed [DW-1:0] dir_s7 [3];
	logic signed [W-1:0] org_s7 [3], org_s8 [3];
	logic signed [PRW-1:0] prod_s8 [3];
	logic hit_q;
	logic signed [W-1:0] clip_q [3];

	// combinational helpers
	logic [DOTW-1:0] dot_rnd;
	logic [PW-1:0] diff_c;
	logic [PRW-1:0] prod_rnd [3];
	logic signed [SUMW-1:0] coord_sum [3];
	logic [W-1:0] coord_sat [3];

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			ctl_s8 <= '0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			// behind the origin, or perpendicular distance beyond the radius
			ctl_s6.valid <= vld_s5;
			ctl_s6.hit <= !neg_s5 && !diff_c[PW-1];
			ctl_s7 <= ctl_sq;
			ctl_s8 <= ctl_s7;
			done_q <= ctl_s8.valid;
		end
	end

	// s1: v = c - o
	// s2: per-axis products for v.d and |v|^2
	// s3: sums
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			vec_s1[i] <= VW'(cen_in[i]) - VW'(org_in[i]);
			dir_s1[i] <= dir_in[i];
			org_s1[i] <= org_in[i];

			pd_s2[i] <= vec_s1[i] * dir_s1[i];
			sq_s2[i] <= vec_s1[i] * vec_s1[i];
			dir_s2[i] <= dir_s1[i];
			org_s2[i] <= org_s1[i];

			dir_s3[i] <= dir_s2[i];
			org_s3[i] <= org_s2[i];
		end
		dot_s3 <= DOTW'(pd_s2[0]) + DOTW'(pd_s2[1]) + DOTW'(pd_s2[2]);
		len2_s3 <= LW'(sq_s2[0]) + LW'(sq_s2[1]) + LW'(sq_s2[2]);
	end

	// s4: t = v.d rounded to Q.8, halves up
	assign dot_rnd = dot_s3 + DOT_HALF;

	always_ff @(posedge clk) begin
		neg_s4 <= dot_s3[DOTW-1];
		t_s4 <= dot_rnd[F+TW-1:F];
		len2_s4 <= len2_s3;
		for (int i = 0; i < 3; i++) begin
			dir_s4[i] <= dir_s3[i];
			org_s4[i] <= org_s3[i];
		end
	end

	// s5: t squared
	always_ff @(posedge clk) begin
		t2_s5 <= t_s4 * t_s4;
		t_s5 <= t_s4;
		neg_s5 <= neg_s4;
		len2_s5 <= len2_s4;
		for (int i = 0; i < 3; i++) begin
			dir_s5[i] <= dir_s4[i];
			org_s5[i] <= org_s4[i];
		end
	end

	// s6: r^2 - (|v|^2 - t^2), negative means a miss
	assign diff_c = PW'(r2_q) + PW'(t2_s5) - PW'(len2_s5);

	always_ff @(posedge clk) begin
		diff_s6 <= diff_c;
		carry_s6.t <= t_s5;
		for (int i = 0; i < 3; i++) begin
			carry_s6.dir[i] <= dir_s5[i];
			carry_s6.org[i] <= org_s5[i];
		end
	end

	// half chord length
	rsfc_isqrt #(
		.ROOT_W(SQW),
		.TAG_W($bits(carry_t))
	) u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.in_ctl(ctl_s6),
		.in_rad(diff_s6),
		.in_tag(carry_s6),
		.out_ctl(ctl_sq),
		.out_root(root_sq),
		.out_tag(carry_sq)
	);

	// s7: far distance along the ray
	// s8: distance times direction
	always_ff @(posedge clk) begin
		dist_s7 <= DSW'(carry_sq.t) + DSW'(root_sq);
		for (int i = 0; i < 3; i++) begin
			dir_s7[i] <= $signed(carry_sq.dir[i]);
			org_s7[i] <= $signed(carry_sq.org[i]);

			prod_s8[i] <= $signed({1'b0, dist_s7}) * dir_s7[i];
			org_s8[i] <= org_s7[i];
		end
	end

	// round to Q.8 with halves up, add origin, saturate
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod_rnd[i] = prod_s8[i] + PROD_HALF;
			coord_sum[i] = SUMW'($signed(prod_rnd[i][PRW-1:F])) + SUMW'(org_s8[i]);
			if ((coord_sum[i][SUMW-1:W-1] != '0) && (coord_sum[i][SUMW-1:W-1] != '1)) begin
				coord_sat[i] = coord_sum[i][SUMW-1] ? CMIN : CMAX;
			end else begin
				coord_sat[i] = coord_sum[i][W-1:0];
			end
		end
	end

	// result registers, zero position on a miss
	always_ff @(posedge clk) begin
		hit_q <= ctl_s8.hit;
		for (int i = 0; i < 3; i++) begin
			clip_q[i] <= ctl_s8.hit ? $signed(coord_sat[i]) : '0;
		end
	end

	assign done = done_q;
	assign hit = hit_q;
	assign clip_x = clip_q[0];
	assign clip_y = clip_q[1];
	assign clip_z = clip_q[2];

endmodule

`default_nettype wire
